// ----- src/lpdd_pkg.sv -----
// Shared types, widths, register indexes and reset values for the leaky peak drop detector.
// Has no dependencies; every other file refers to it by scoped names.
package lpdd_pkg;

	localparam int FRACTION_BITS_DEF = 16;

	localparam int SAMPLE_W   = 8;
	localparam int LEVEL_W    = 24;
	localparam int WEIGHT_W   = 8;
	localparam int DROP_W     = 24;
	localparam int LEAK_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DETECTION_DROP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK_STEP        = 2'd2;

	localparam logic [WEIGHT_W-1:0] SMOOTHING_WEIGHT_RST = 8'd235;
	localparam logic [DROP_W-1:0]   DETECTION_DROP_RST   = 24'd163840;
	localparam logic [LEAK_W-1:0]   LEAK_STEP_RST        = 16'd16;

	typedef struct packed {
		logic [WEIGHT_W-1:0] smoothing_weight;
		logic [DROP_W-1:0]   detection_drop;
		logic [LEAK_W-1:0]   leak_step;
	} cfg_t;

endpackage

// ----- src/lpdd_cfg_regs.sv -----
// Configuration register file: weight, detection drop and leak step.
// Depends on lpdd_pkg for widths, register indexes and reset values.
module lpdd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpdd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output lpdd_pkg::cfg_t                    cfg
);

	lpdd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smoothing_weight <= lpdd_pkg::SMOOTHING_WEIGHT_RST;
			cfg_q.detection_drop   <= lpdd_pkg::DETECTION_DROP_RST;
			cfg_q.leak_step        <= lpdd_pkg::LEAK_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lpdd_pkg::REG_SMOOTHING_WEIGHT: begin
					cfg_q.smoothing_weight <= cfg_data[lpdd_pkg::WEIGHT_W-1:0];
				end
				lpdd_pkg::REG_DETECTION_DROP: begin
					cfg_q.detection_drop <= cfg_data[lpdd_pkg::DROP_W-1:0];
				end
				lpdd_pkg::REG_LEAK_STEP: begin
					cfg_q.leak_step <= cfg_data[lpdd_pkg::LEAK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/lpdd_iir.sv -----
// First-order IIR smoothing of the range sample, holding the smoothed level register.
// Depends on lpdd_pkg for widths.
module lpdd_iir #(
	parameter int FRACTION_BITS = lpdd_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               update,
	input  logic [lpdd_pkg::WEIGHT_W-1:0]      weight,
	input  logic [lpdd_pkg::SAMPLE_W-1:0]      sample,
	output logic [lpdd_pkg::LEVEL_W-1:0]       level_next,
	output logic [lpdd_pkg::LEVEL_W-1:0]       level
);

	localparam int OLD_W  = lpdd_pkg::WEIGHT_W + lpdd_pkg::LEVEL_W;
	localparam int NEW_W  = lpdd_pkg::WEIGHT_W + 1 + lpdd_pkg::SAMPLE_W;
	localparam int WIDE_W = ((NEW_W + FRACTION_BITS) > OLD_W) ?
		(NEW_W + FRACTION_BITS) : OLD_W;
	localparam int SUM_W  = WIDE_W + 1;
	localparam int SHR_W  = SUM_W - lpdd_pkg::WEIGHT_W;

	logic [lpdd_pkg::LEVEL_W-1:0]  level_q;
	logic [lpdd_pkg::WEIGHT_W:0]   new_weight;
	logic [OLD_W-1:0]              old_term;
	logic [NEW_W-1:0]              new_term;
	logic [SUM_W-1:0]              sum;
	logic [SHR_W-1:0]              shifted;

	always_comb begin
		new_weight = (9'd1 << lpdd_pkg::WEIGHT_W) - {1'b0, weight};
		old_term   = OLD_W'(weight) * OLD_W'(level_q);
		new_term   = NEW_W'(new_weight) * NEW_W'(sample);
		sum        = SUM_W'(old_term) + (SUM_W'(new_term) << FRACTION_BITS);
		shifted    = sum[SUM_W-1:lpdd_pkg::WEIGHT_W];
		if (|shifted[SHR_W-1:lpdd_pkg::LEVEL_W]) begin
			level_next = '1;
		end else begin
			level_next = shifted[lpdd_pkg::LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (update) begin
			level_q <= level_next;
		end
	end

	assign level = level_q;

endmodule

// ----- src/lpdd_peak.sv -----
// Held peak with raise, drop detection and leakage, holding the peak register.
// Depends on lpdd_pkg for widths.
module lpdd_peak (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           update,
	input  logic                           tick,
	input  logic [lpdd_pkg::LEVEL_W-1:0]   level_next,
	input  logic [lpdd_pkg::DROP_W-1:0]    drop,
	input  logic [lpdd_pkg::LEAK_W-1:0]    leak,
	output logic                           present_next,
	output logic [lpdd_pkg::LEVEL_W-1:0]   peak
);

	logic [lpdd_pkg::LEVEL_W-1:0] peak_q;
	logic [lpdd_pkg::LEVEL_W-1:0] raised;
	logic [lpdd_pkg::LEVEL_W-1:0] leak_ext;
	logic [lpdd_pkg::LEVEL_W-1:0] peak_next;

	always_comb begin
		leak_ext     = lpdd_pkg::LEVEL_W'(leak);
		raised       = (level_next > peak_q) ? level_next : peak_q;
		present_next = (raised >= drop) && (level_next < (raised - drop));
		if (tick && (raised >= leak_ext)) begin
			peak_next = raised - leak_ext;
		end else begin
			peak_next = raised;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (update) begin
			peak_q <= peak_next;
		end
	end

	assign peak = peak_q;

	// Without a tick the peak can never end up below the level just taken.
	a_peak_covers_level: assert property (@(posedge clk) disable iff (!arst_n)
		update && !tick |=> peak_q >= $past(level_next))
		else $error("held peak fell below the new level without a tick");

endmodule

// ----- src/leaky_peak_drop_detector.sv -----
// Leaky peak drop detector: smooths 8-bit range samples, tracks a leaking peak and flags
// presence when the level drops far enough below it. One item is taken every cycle while
// the output is free. An accepted item waits in an input register; its result is then
// registered in the filter level, peak and presence registers together with the output
// valid stage, and is held there until it is taken.
module leaky_peak_drop_detector #(
	parameter int FRACTION_BITS = lpdd_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpdd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lpdd_pkg::SAMPLE_W-1:0]     range_sample,
	input  logic                              leak_tick,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              present,
	output logic [lpdd_pkg::LEVEL_W-1:0]      filtered_level,
	output logic [lpdd_pkg::LEVEL_W-1:0]      peak_level
);

	lpdd_pkg::cfg_t                 cfg;
	logic                           valid_s1;
	logic [lpdd_pkg::SAMPLE_W-1:0]  sample_s1;
	logic                           tick_s1;
	logic                           valid_s2;
	logic                           present_s2;
	logic                           advance;
	logic                           update;
	logic                           present_next;
	logic [lpdd_pkg::LEVEL_W-1:0]   level_next;

	assign advance  = !valid_s2 || out_ready;
	assign update   = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	lpdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpdd_iir #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_iir (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (update),
		.weight     (cfg.smoothing_weight),
		.sample     (sample_s1),
		.level_next (level_next),
		.level      (filtered_level)
	);

	lpdd_peak u_peak (
		.clk          (clk),
		.arst_n       (arst_n),
		.update       (update),
		.tick         (tick_s1),
		.level_next   (level_next),
		.drop         (cfg.detection_drop),
		.leak         (cfg.leak_step),
		.present_next (present_next),
		.peak         (peak_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= range_sample;
			tick_s1   <= leak_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			present_s2 <= present_next;
		end
	end

	assign out_valid = valid_s2;
	assign present   = present_s2;

	// A stalled item in the input register keeps its payload.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(sample_s1) && $stable(tick_s1))
		else $error("input register lost or changed a stalled item");

	// Every transfer into the input register is followed by an item in that register.
	a_s1_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	// A presence report implies the level lies below the peak before its leakage.
	a_present_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && present |->
			({2'b00, filtered_level} + {2'b00, cfg.detection_drop}) <
			({2'b00, peak_level} + {10'b0, cfg.leak_step}))
		else $error("presence reported without a sufficient drop below the peak");

endmodule
